FILE: rtl/core/pidpc_pkg.sv
// pidpc_pkg: shared types and constants for the PID position controller.
// Payload structs, configuration struct, register indexes, controller commands.
// No dependencies.
package pidpc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned GAIN_W    = 31;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned TERM_W    = PROD_W - FRAC_BITS;
  localparam int unsigned ISUM_W    = TERM_W + 1;
  localparam int unsigned ACC_W     = TERM_W + 2;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned IDX_W     = 3;

  // register indexes, byte address = 4 * index
  localparam logic [IDX_W-1:0] REG_KP        = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI        = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD        = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_MAX   = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_MIN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_INT_LIMIT = 3'd5;
  localparam logic [IDX_W-1:0] REG_INT_DT    = 3'd6;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     out_clamped;
    logic                     int_clamped;
  } out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] out_min;
    logic        [GAIN_W-1:0] int_limit;
    logic        [GAIN_W-1:0] int_dt;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_DT,
    MUL_KP,
    MUL_KI
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic     ld_in;
    logic     calc_err;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     mul_kd;
    logic     int_upd;
    acc_op_e  acc_op;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } status_t;

endpackage

FILE: rtl/core/pidpc_regs.sv
// pidpc_regs: APB-style configuration register file for the PID controller.
// Depends on pidpc_pkg.
module pidpc_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pidpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output pidpc_pkg::cfg_t                 cfg_o
);
  import pidpc_pkg::*;

  cfg_t             cfg_q;
  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr    = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp        <= 32'sd1048576;
      cfg_q.ki        <= '0;
      cfg_q.kd        <= 32'sd65536;
      cfg_q.out_max   <= 32'sd131072;
      cfg_q.out_min   <= -32'sd131072;
      cfg_q.int_limit <= 31'd196608;
      cfg_q.int_dt    <= 31'd655;
    end else if (wr) begin
      unique case (idx)
        REG_KP:        cfg_q.kp        <= pwdata;
        REG_KI:        cfg_q.ki        <= pwdata;
        REG_KD:        cfg_q.kd        <= pwdata;
        REG_OUT_MAX:   cfg_q.out_max   <= pwdata;
        REG_OUT_MIN:   cfg_q.out_min   <= pwdata;
        REG_INT_LIMIT: cfg_q.int_limit <= pwdata[GAIN_W-1:0];
        REG_INT_DT:    cfg_q.int_dt    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KP:        prdata = cfg_q.kp;
      REG_KI:        prdata = cfg_q.ki;
      REG_KD:        prdata = cfg_q.kd;
      REG_OUT_MAX:   prdata = cfg_q.out_max;
      REG_OUT_MIN:   prdata = cfg_q.out_min;
      REG_INT_LIMIT: prdata = {1'b0, cfg_q.int_limit};
      REG_INT_DT:    prdata = {1'b0, cfg_q.int_dt};
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/pidpc_ctrl.sv
// pidpc_ctrl: sequencer for the PID controller, one sample at a time.
// Issues datapath commands step by step. Depends on pidpc_pkg.
module pidpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pidpc_pkg::status_t   status_i,
  output pidpc_pkg::cmd_t      cmd_o
);
  import pidpc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_MDT  = 3'd2;
  localparam logic [2:0] S_INT  = 3'd3;
  localparam logic [2:0] S_MKI  = 3'd4;
  localparam logic [2:0] S_MKD  = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.acc_op   = ACC_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_ERR;
        end
      end
      S_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d        = S_MDT;
      end
      S_MDT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DT;
        state_d       = S_INT;
      end
      S_INT: begin
        cmd_o.int_upd = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KP;
        state_d       = S_MKI;
      end
      S_MKI: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KI;
        state_d       = S_MKD;
      end
      S_MKD: begin
        cmd_o.acc_op = ACC_ADD;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_kd = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // wait while the previous result still sits in the output register
        if (!status_i.out_stall) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/pidpc_dp.sv
// pidpc_dp: PID datapath with one shared 32x32 multiplier, integral and
// output clamps, and the output register. Depends on pidpc_pkg.
module pidpc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidpc_pkg::cmd_t    cmd_i,
  output pidpc_pkg::status_t status_o,
  input  pidpc_pkg::cfg_t    cfg_i,
  input  pidpc_pkg::in_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pidpc_pkg::out_t    out_data_o
);
  import pidpc_pkg::*;

  function automatic logic signed [DATA_W-1:0] sat_dw(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = {v[DATA_W], {(DATA_W-1){~v[DATA_W]}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  logic signed [DATA_W-1:0] sp_q, meas_q, prev_q, err_q, diff_q, integral_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [TERM_W-1:0] term;
  logic signed [ISUM_W-1:0] isum, lim_pos, lim_neg;
  logic signed [ACC_W-1:0]  acc_q, out_hi, out_lo, clamp_hi;
  logic signed [DATA_W-1:0] integral_d;
  logic                     ic_d, ic_q, oc_hi, oc_lo;
  logic                     out_valid_q;
  out_t                     out_q;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = err_q;
    mul_b = cfg_i.kp;
    if (cmd_i.mul_kd) begin
      mul_a = diff_q;
      mul_b = cfg_i.kd;
    end else begin
      case (cmd_i.mul_sel)
        MUL_DT: begin
          mul_a = err_q;
          mul_b = {1'b0, cfg_i.int_dt};
        end
        MUL_KI: begin
          mul_a = integral_q;
          mul_b = cfg_i.ki;
        end
        default: begin
          mul_a = err_q;
          mul_b = cfg_i.kp;
        end
      endcase
    end
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  // arithmetic shift: floor of the scaled product
  assign term   = prod_q[PROD_W-1:FRAC_BITS];

  // integral update and symmetric clamp
  assign lim_pos = ISUM_W'($signed({1'b0, cfg_i.int_limit}));
  assign lim_neg = -lim_pos;
  assign isum    = ISUM_W'(integral_q) + ISUM_W'(term);

  always_comb begin
    integral_d = isum[DATA_W-1:0];
    ic_d       = 1'b0;
    if (isum > lim_pos) begin
      integral_d = lim_pos[DATA_W-1:0];
      ic_d       = 1'b1;
    end else if (isum < lim_neg) begin
      integral_d = lim_neg[DATA_W-1:0];
      ic_d       = 1'b1;
    end
  end

  // output clamp: max first, then min, so inverted limits give out_min
  assign out_hi   = ACC_W'(cfg_i.out_max);
  assign out_lo   = ACC_W'(cfg_i.out_min);
  assign oc_hi    = acc_q > out_hi;
  assign clamp_hi = oc_hi ? out_hi : acc_q;
  assign oc_lo    = clamp_hi < out_lo;

  assign status_o.out_stall = out_valid_q & ~out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      integral_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.calc_err) begin
        prev_q <= meas_q;
      end
      if (cmd_i.int_upd) begin
        integral_q <= integral_d;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      sp_q   <= in_data_i.setpoint;
      meas_q <= in_data_i.measured;
    end
    if (cmd_i.calc_err) begin
      err_q  <= sat_dw((DATA_W+1)'(sp_q) - (DATA_W+1)'(meas_q));
      diff_q <= sat_dw((DATA_W+1)'(meas_q) - (DATA_W+1)'(prev_q));
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.int_upd) begin
      ic_q <= ic_d;
    end
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= ACC_W'(term);
      ACC_ADD:  acc_q <= acc_q + ACC_W'(term);
      default:  ;
    endcase
    if (cmd_i.out_ld) begin
      out_q.drive       <= oc_lo ? out_lo[DATA_W-1:0] : clamp_hi[DATA_W-1:0];
      out_q.out_clamped <= oc_hi | oc_lo;
      out_q.int_clamped <= ic_q;
    end
  end

endmodule

FILE: rtl/core/pid_position_controller_unit.sv
// pid_position_controller_unit: top level of the PID position controller.
// Depends on pidpc_pkg, pidpc_regs, pidpc_ctrl, pidpc_dp.
//
// Positional PID with derivative on measurement, signed Q16.16 throughout.
// A sample is taken in the idle state, then goes through seven sequencer steps
// in which a single shared 32x32 multiplier forms error*int_dt, error*kp,
// integral*ki and diff*kd in turn, with the integral and output clamps in
// between. The result lands in an output register; the next sample is taken
// once that register has been loaded; a consumer that holds off out_ready_i
// delays the next sample by its stall. The user must write configuration over
// the APB port only while no sample is in flight; the block does not check it.
module pid_position_controller_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pidpc_pkg::in_t               in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pidpc_pkg::out_t              out_data_o
);
  import pidpc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  pidpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pidpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
